[src/fflba_pkg.sv]
package fflba_pkg;

	localparam int POOL_SLOTS = 64;
	localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
	localparam int OFF_W      = 48;
	localparam int SIZE_W     = 32;
	localparam int STEP_W     = 16;
	localparam int REUSE_W    = 16;

	typedef logic [SLOT_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [OFF_W-1:0]   off_t;
	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic [REUSE_W-1:0] reuse_t;
	typedef logic [5:0]         slot_id_t;
	typedef logic [6:0]         used_t;
	typedef logic [1:0]         status_t;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam status_t ST_REUSE = 2'd0;
	localparam status_t ST_NEW   = 2'd1;
	localparam status_t ST_FAIL  = 2'd2;
	localparam status_t ST_CLEAR = 2'd3;

	localparam reuse_t REUSE_MAX = '1;

	typedef struct packed {
		logic  req_type;
		step_t lifetime_start;
		step_t lifetime_last;
		size_t size_bytes;
	} req_t;

	typedef struct packed {
		status_t  status;
		slot_id_t slot_id;
		off_t     slot_offset;
		used_t    slots_used;
		off_t     total_bytes;
		reuse_t   reuse_total;
	} rsp_t;

	typedef struct packed {
		off_t  base;
		size_t size;
		step_t free_after;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic ovf;
		off_t end_next;
	} fit_t;

endpackage

[src/fflba_mem.sv]
module fflba_mem (
	input  logic                clk,
	input  logic                we,
	input  fflba_pkg::idx_t     waddr,
	input  fflba_pkg::entry_t   wdata,
	input  fflba_pkg::idx_t     raddr,
	output fflba_pkg::entry_t   rdata
);

	fflba_pkg::entry_t mem [fflba_pkg::POOL_SLOTS];
	fflba_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/fflba_fit.sv]
module fflba_fit (
	input  fflba_pkg::entry_t entry,
	input  fflba_pkg::step_t  start_step,
	input  fflba_pkg::size_t  size,
	input  fflba_pkg::off_t   end_offset,
	output fflba_pkg::fit_t   fit
);

	logic [fflba_pkg::OFF_W:0] sum;

	assign sum = {1'b0, end_offset} + (fflba_pkg::OFF_W + 1)'(size);

	assign fit.hit      = (entry.free_after < start_step) && (entry.size >= size);
	assign fit.ovf      = sum[fflba_pkg::OFF_W];
	assign fit.end_next = sum[fflba_pkg::OFF_W-1:0];

endmodule

[src/first_fit_lifetime_buffer_allocator.sv]
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------
// request   | start in, busy out        | req  (fflba_pkg::req_t)
// result    | done out, one-cycle pulse | rsp  (fflba_pkg::rsp_t)
//
// A clear request is answered by done in the next cycle, and busy stays low.
// An allocate request scans the slot pool one entry per cycle through the single
// read port of the slot memory.
// Reset clears the counters and the sequencer; the slot memory needs no clearing.
// The receiver cannot stall: done is a strobe and a new request may start with it.
module first_fit_lifetime_buffer_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fflba_pkg::req_t   req,
	output logic              done,
	output fflba_pkg::rsp_t   rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic                state_q, state_d;
	fflba_pkg::cnt_t     idx_q, idx_d;
	logic                cmp_vld_q, cmp_vld_d;
	fflba_pkg::idx_t     cmp_idx_q, cmp_idx_d;
	fflba_pkg::cnt_t     cnt_q, cnt_d;
	fflba_pkg::off_t     end_q, end_d;
	fflba_pkg::reuse_t   reuse_q, reuse_d;
	logic                done_q, done_d;
	fflba_pkg::rsp_t     rsp_q, rsp_d;
	fflba_pkg::req_t     req_q;

	fflba_pkg::entry_t   rdata;
	fflba_pkg::entry_t   wdata;
	fflba_pkg::idx_t     waddr;
	logic                we;
	fflba_pkg::fit_t     fit;

	logic issue;
	logic hit;
	logic full;

	assign busy  = (state_q == S_SCAN);
	assign issue = (idx_q < cnt_q);
	assign hit   = cmp_vld_q && fit.hit;
	assign full  = (cnt_q == fflba_pkg::cnt_t'(fflba_pkg::POOL_SLOTS));

	fflba_fit u_fit (
		.entry      (rdata),
		.start_step (req_q.lifetime_start),
		.size       (req_q.size_bytes),
		.end_offset (end_q),
		.fit        (fit)
	);

	fflba_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q[fflba_pkg::SLOT_W-1:0]),
		.rdata (rdata)
	);

	// reuse rewrites the hit entry with its new free time; a miss appends at the end unless full or on offset overflow
	always_comb begin
		we                = 1'b0;
		waddr             = hit ? cmp_idx_q : cnt_q[fflba_pkg::SLOT_W-1:0];
		wdata.free_after  = req_q.lifetime_last;
		wdata.base        = hit ? rdata.base : end_q;
		wdata.size        = hit ? rdata.size : req_q.size_bytes;
		if (state_q == S_SCAN) begin
			we = hit || (!issue && !full && !fit.ovf);
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		cnt_d     = cnt_q;
		end_d     = end_q;
		reuse_d   = reuse_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.req_type == fflba_pkg::REQ_CLEAR) begin
						cnt_d             = '0;
						end_d             = '0;
						reuse_d           = '0;
						done_d            = 1'b1;
						rsp_d             = '0;
						rsp_d.status      = fflba_pkg::ST_CLEAR;
					end else begin
						state_d   = S_SCAN;
						idx_d     = '0;
						cmp_vld_d = 1'b0;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (reuse_q != fflba_pkg::REUSE_MAX) begin
						reuse_d = reuse_q + 1'b1;
					end
					done_d            = 1'b1;
					state_d           = S_IDLE;
					rsp_d.status      = fflba_pkg::ST_REUSE;
					rsp_d.slot_id     = fflba_pkg::slot_id_t'(cmp_idx_q);
					rsp_d.slot_offset = rdata.base;
					rsp_d.slots_used  = fflba_pkg::used_t'(cnt_q);
					rsp_d.total_bytes = end_q;
					rsp_d.reuse_total = reuse_d;
				end else if (issue) begin
					// compare this entry next cycle while the following read goes out
					idx_d     = idx_q + 1'b1;
					cmp_vld_d = 1'b1;
					cmp_idx_d = idx_q[fflba_pkg::SLOT_W-1:0];
				end else begin
					done_d    = 1'b1;
					state_d   = S_IDLE;
					cmp_vld_d = 1'b0;
					if (full || fit.ovf) begin
						rsp_d.status      = fflba_pkg::ST_FAIL;
						rsp_d.slot_id     = '0;
						rsp_d.slot_offset = '0;
						rsp_d.slots_used  = fflba_pkg::used_t'(cnt_q);
						rsp_d.total_bytes = end_q;
						rsp_d.reuse_total = reuse_q;
					end else begin
						cnt_d             = cnt_q + 1'b1;
						end_d             = fit.end_next;
						rsp_d.status      = fflba_pkg::ST_NEW;
						rsp_d.slot_id     = fflba_pkg::slot_id_t'(cnt_q);
						rsp_d.slot_offset = end_q;
						rsp_d.slots_used  = fflba_pkg::used_t'(cnt_d);
						rsp_d.total_bytes = fit.end_next;
						rsp_d.reuse_total = reuse_q;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			cnt_q     <= '0;
			end_q     <= '0;
			reuse_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			cmp_vld_q <= cmp_vld_d;
			cnt_q     <= cnt_d;
			end_q     <= end_d;
			reuse_q   <= reuse_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= cmp_idx_d;
		rsp_q     <= rsp_d;
		if (start && !busy) begin
			req_q <= req;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[src/fflba_chk.sv]
module fflba_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input fflba_pkg::req_t req,
	input logic            done,
	input fflba_pkg::rsp_t rsp
);

	// results come out only once the scan has let go of busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_clear_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == fflba_pkg::REQ_CLEAR)
		|=> done && (rsp.status == fflba_pkg::ST_CLEAR))
		else $error("clear did not answer next cycle");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req.req_type == fflba_pkg::REQ_ALLOC) |=> busy && !done)
		else $error("allocate did not start a scan");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((rsp.status == fflba_pkg::ST_FAIL) || (rsp.status == fflba_pkg::ST_CLEAR))
		|-> (rsp.slot_id == '0) && (rsp.slot_offset == '0))
		else $error("slot fields not zero");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == fflba_pkg::ST_CLEAR)
		|-> (rsp.slots_used == '0) && (rsp.total_bytes == '0) && (rsp.reuse_total == '0))
		else $error("clear left counters set");

endmodule

bind first_fit_lifetime_buffer_allocator fflba_chk u_fflba_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
